[hw/rtl/qdt_pkg.sv]
// Package with shared types and constants for the quoted delimiter tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package qdt_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned DELIM_W       = 64;
    localparam int unsigned QUOTE_W       = 32;
    localparam int unsigned PACK_W        = 64;
    localparam int unsigned MAX_SLOTS     = 8;
    localparam int unsigned DELIM_SLOTS_D = 8;
    localparam int unsigned QUOTE_SLOTS_D = 4;
    localparam int unsigned CFG_INDEX_W   = 2;

    localparam logic [DELIM_W-1:0] DELIM_RESET = 64'h0000_0000_0000_0920;
    localparam logic [QUOTE_W-1:0] QUOTE_RESET = 32'h0000_0022;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELIMITER_CHARS = 2'd0,
        CFG_QUOTE_CHARS     = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic is_quote;
        logic is_delim;
    } t_byte_class;

    typedef struct packed {
        logic              has_result;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              token_end;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/qdt_in_if.sv]
// Input channel carrying one string byte or an end-of-string marker per word.
`timescale 1ns / 1ps
`default_nettype none
interface qdt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface
`default_nettype wire

[hw/rtl/qdt_out_if.sv]
// Output channel carrying one token byte or a token-end mark per word.
`timescale 1ns / 1ps
`default_nettype none
interface qdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;

    modport source (output valid, output out_byte, output byte_valid, output token_end,
                    input ready);
    modport sink (input valid, input out_byte, input byte_valid, input token_end,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/qdt_match.sv]
// Compares one byte against a set of packed character slots.
`timescale 1ns / 1ps
`default_nettype none
module qdt_match #(
    parameter int unsigned SLOTS = qdt_pkg::MAX_SLOTS
) (
    input  wire logic [qdt_pkg::PACK_W-1:0] i_packed,
    input  wire logic [qdt_pkg::BYTE_W-1:0] i_byte,
    output logic                            o_hit
);
    import qdt_pkg::*;

    localparam int unsigned USED = (SLOTS > MAX_SLOTS) ? MAX_SLOTS : SLOTS;

    always_comb begin
        logic [BYTE_W-1:0] slot;
        o_hit = 1'b0;
        for (int unsigned i = 0; i < USED; i++) begin
            slot = i_packed[BYTE_W*i +: BYTE_W];
            if ((slot != '0) && (slot == i_byte)) begin
                o_hit = 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/qdt_step.sv]
// Tokenizer state flags and the per-word decision logic.
`timescale 1ns / 1ps
`default_nettype none
module qdt_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire logic [qdt_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                        i_eos,
    input  wire qdt_pkg::t_byte_class        i_class,
    output qdt_pkg::t_result                 o_result
);
    import qdt_pkg::*;

    logic r_in_quote, r_dropping, r_has_body, r_in_run;
    logic n_in_quote, n_dropping, n_has_body, n_in_run;

    always_comb begin
        n_in_quote = r_in_quote;
        n_dropping = r_dropping;
        n_has_body = r_has_body;
        n_in_run   = r_in_run;
        o_result   = '0;
        if (i_eos) begin
            o_result.has_result = r_has_body;
            o_result.token_end  = r_has_body;
            n_in_quote = 1'b0;
            n_dropping = 1'b0;
            n_has_body = 1'b0;
            n_in_run   = 1'b0;
        end else if (i_class.is_quote) begin
            n_in_run = 1'b0;
            if (r_in_quote) begin
                n_in_quote = 1'b0;
                if (r_has_body) begin
                    n_dropping = 1'b1;
                end
            end else begin
                n_in_quote = 1'b1;
                if (r_has_body && !r_dropping) begin
                    o_result.has_result = 1'b1;
                    o_result.out_byte   = i_byte;
                    o_result.byte_valid = 1'b1;
                end
            end
        end else if (!r_in_quote && i_class.is_delim) begin
            if (!r_in_run) begin
                o_result.has_result = 1'b1;
                o_result.token_end  = 1'b1;
                n_in_run   = 1'b1;
                n_has_body = 1'b0;
                n_dropping = 1'b0;
            end
        end else begin
            n_in_run   = 1'b0;
            n_has_body = 1'b1;
            if (!r_dropping) begin
                o_result.has_result = 1'b1;
                o_result.out_byte   = i_byte;
                o_result.byte_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote <= 1'b0;
            r_dropping <= 1'b0;
            r_has_body <= 1'b0;
            r_in_run   <= 1'b0;
        end else if (i_advance) begin
            r_in_quote <= n_in_quote;
            r_dropping <= n_dropping;
            r_has_body <= n_has_body;
            r_in_run   <= n_in_run;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/quoted_delimiter_tokenizer.sv]
// Top level of the streaming tokenizer with quote handling.
// An accepted input word passes through the input register and then the output register.
// Throughput: one input word per cycle while the output register is free or the word yields no output.
// Words that produce no output still pass through the input register.
// Reset clears the tokenizer flags and restores the default delimiter
// (space, tab) and quote (double quote) sets.
`timescale 1ns / 1ps
`default_nettype none
module quoted_delimiter_tokenizer #(
    parameter int unsigned DELIM_SLOTS = qdt_pkg::DELIM_SLOTS_D,
    parameter int unsigned QUOTE_SLOTS = qdt_pkg::QUOTE_SLOTS_D
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    qdt_in_if.sink                               i_in,
    qdt_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [qdt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [qdt_pkg::DELIM_W-1:0]     i_cfg_data
);
    import qdt_pkg::*;

    logic [DELIM_W-1:0] r_delim;
    logic [QUOTE_W-1:0] r_quote;

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_eos;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_byte_valid;
    logic              r_out_token_end;

    t_byte_class cls;
    t_result     res;
    logic        out_free;
    logic        advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_quote <= QUOTE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIMITER_CHARS: r_delim <= i_cfg_data;
                CFG_QUOTE_CHARS:     r_quote <= i_cfg_data[QUOTE_W-1:0];
                default: ;
            endcase
        end
    end

    qdt_match #(.SLOTS(QUOTE_SLOTS)) u_quote_match (
        .i_packed ({{(PACK_W-QUOTE_W){1'b0}}, r_quote}),
        .i_byte   (r_s1_byte),
        .o_hit    (cls.is_quote)
    );

    qdt_match #(.SLOTS(DELIM_SLOTS)) u_delim_match (
        .i_packed (r_delim),
        .i_byte   (r_s1_byte),
        .o_hit    (cls.is_delim)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_s1_valid && (out_free || !res.has_result);

    qdt_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_s1_byte),
        .i_eos     (r_s1_eos),
        .i_class   (cls),
        .o_result  (res)
    );

    assign i_in.ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.in_byte;
            r_s1_eos  <= i_in.end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && res.has_result) begin
            r_out_byte       <= res.out_byte;
            r_out_byte_valid <= res.byte_valid;
            r_out_token_end  <= res.token_end;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.byte_valid = r_out_byte_valid;
    assign o_out.token_end  = r_out_token_end;
endmodule
`default_nettype wire

[sim/quoted_delimiter_tokenizer_tb.sv]
// Self-checking testbench for the quoted delimiter tokenizer with random stimulus and stalls.
`timescale 1ns / 1ps
module quoted_delimiter_tokenizer_tb;

    import qdt_pkg::*;

    localparam int unsigned TB_DELIM_SLOTS = DELIM_SLOTS_D;
    localparam int unsigned TB_QUOTE_SLOTS = QUOTE_SLOTS_D;
    localparam int unsigned RESET_CYCLES   = 8;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned IDLE_PCT       = 30;
    localparam int unsigned STALL_AFTER    = 400;
    localparam int unsigned STALL_CYCLES   = 200;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS    = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef struct {
        logic [7:0] in_byte;
        logic       eos;
    } t_string_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DELIM_W-1:0] cfg_data = '0;

    qdt_in_if  in_if ();
    qdt_out_if out_if ();

    quoted_delimiter_tokenizer #(
        .DELIM_SLOTS(TB_DELIM_SLOTS),
        .QUOTE_SLOTS(TB_QUOTE_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if.sink),
        .o_out(out_if.source),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_string_word string_words_pending[$];
    t_result      token_words_due[$];

    logic [DELIM_W-1:0] delim_set = DELIM_RESET;
    logic [QUOTE_W-1:0] quote_set = QUOTE_RESET;
    logic in_quote = 1'b0;
    logic dropping = 1'b0;
    logic has_body = 1'b0;
    logic in_delim_run = 1'b0;

    logic in_took = 1'b0;
    logic calm = 1'b0;
    int unsigned out_words = 0;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    logic stall_done = 1'b0;

    function automatic logic slot_hit(input logic [63:0] set_bits, input int unsigned slots,
                                      input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < slots && i < MAX_SLOTS; i++) begin
            if (set_bits[8*i +: 8] != 8'h00 && set_bits[8*i +: 8] == b) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_result tokenize_byte(input t_string_word w);
        t_result r;
        r = '0;
        if (w.eos) begin
            if (has_body) begin
                r.has_result = 1'b1;
                r.token_end = 1'b1;
            end
            in_quote = 1'b0;
            dropping = 1'b0;
            has_body = 1'b0;
            in_delim_run = 1'b0;
        end else if (slot_hit({32'h0, quote_set}, TB_QUOTE_SLOTS, w.in_byte)) begin
            in_delim_run = 1'b0;
            if (in_quote) begin
                in_quote = 1'b0;
                if (has_body) begin
                    dropping = 1'b1;
                end
            end else begin
                in_quote = 1'b1;
                if (has_body && !dropping) begin
                    r.has_result = 1'b1;
                    r.out_byte = w.in_byte;
                    r.byte_valid = 1'b1;
                end
            end
        end else if (!in_quote && slot_hit(delim_set, TB_DELIM_SLOTS, w.in_byte)) begin
            if (!in_delim_run) begin
                r.has_result = 1'b1;
                r.token_end = 1'b1;
                in_delim_run = 1'b1;
                has_body = 1'b0;
                dropping = 1'b0;
            end
        end else begin
            in_delim_run = 1'b0;
            has_body = 1'b1;
            if (!dropping) begin
                r.has_result = 1'b1;
                r.out_byte = w.in_byte;
                r.byte_valid = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_member(input logic [63:0] set_bits,
                                               input int unsigned slots);
        logic [7:0] members[$];
        for (int i = 0; i < slots && i < MAX_SLOTS; i++) begin
            if (set_bits[8*i +: 8] != 8'h00) begin
                members.insert(members.size(), set_bits[8*i +: 8]);
            end
        end
        if (members.size() == 0) begin
            return 8'($urandom_range(255));
        end
        return members[$urandom_range(members.size() - 1)];
    endfunction

    function automatic logic [63:0] random_set(input int unsigned zero_pct);
        logic [63:0] v;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            v[8*i +: 8] = ($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
        end
        return v;
    endfunction

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic add_word(input logic [7:0] b, input logic eos);
        t_string_word w;
        w.in_byte = b;
        w.eos = eos;
        string_words_pending.insert(string_words_pending.size(), w);
    endtask

    task automatic add_strings(input int unsigned count);
        int unsigned r;
        for (int unsigned n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                add_word(8'($urandom_range(255)), 1'b1);
            end else if (r < 32) begin
                add_word(pick_member(delim_set, TB_DELIM_SLOTS), 1'b0);
            end else if (r < 45) begin
                add_word(pick_member({32'h0, quote_set}, TB_QUOTE_SLOTS), 1'b0);
            end else if (r < 72) begin
                add_word(8'($urandom_range(255)), 1'b0);
            end else begin
                add_word(8'($urandom_range(8'h7a, 8'h61)), 1'b0);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DELIM_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DELIMITER_CHARS) begin
            delim_set = value;
        end else if (idx == CFG_QUOTE_CHARS) begin
            quote_set = value[QUOTE_W-1:0];
        end
    endtask

    task automatic settle();
        while (string_words_pending.size() != 0 || token_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_took) begin
                void'(string_words_pending.pop_front());
            end
            if (in_if.valid && !in_took) begin
                in_if.valid <= 1'b1;
            end else if (string_words_pending.size() != 0 &&
                         (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_if.valid <= 1'b1;
                in_if.in_byte <= string_words_pending[0].in_byte;
                in_if.end_of_string <= string_words_pending[0].eos;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!stall_done && out_words >= STALL_AFTER) begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_result due;
        t_result word;
        in_took <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                out_words <= out_words + 1;
                if (token_words_due.size() == 0) begin
                    report($sformatf("unexpected word out_byte=%02h byte_valid=%0b token_end=%0b",
                                     out_if.out_byte, out_if.byte_valid, out_if.token_end));
                end else begin
                    due = token_words_due.pop_front();
                    if (out_if.out_byte !== due.out_byte || out_if.byte_valid !== due.byte_valid ||
                        out_if.token_end !== due.token_end) begin
                        report($sformatf({"expected out_byte=%02h byte_valid=%0b token_end=%0b,",
                                          " got out_byte=%02h byte_valid=%0b token_end=%0b"},
                                         due.out_byte, due.byte_valid, due.token_end,
                                         out_if.out_byte, out_if.byte_valid, out_if.token_end));
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                word = tokenize_byte('{in_byte: in_if.in_byte, eos: in_if.end_of_string});
                if (word.has_result) begin
                    token_words_due.insert(token_words_due.size(), word);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quoted_delimiter_tokenizer regression: fail");
            $finish;
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.end_of_string = 1'b0;
        out_if.ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_word(CH_SPACE, 1'b0);
        add_word(CH_TAB, 1'b0);
        add_word(CH_DQUOTE, 1'b0);
        add_word(CH_SPACE, 1'b0);
        add_word(8'h61, 1'b0);
        add_word(CH_DQUOTE, 1'b0);
        add_word(8'h62, 1'b0);
        add_word(CH_DQUOTE, 1'b0);
        add_word(CH_SPACE, 1'b0);
        add_word(CH_DQUOTE, 1'b0);
        add_word(CH_SPACE, 1'b0);
        add_word(8'h78, 1'b0);
        add_word(CH_DQUOTE, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(CH_DQUOTE, 1'b0);
        add_word(8'hff, 1'b1);
        add_word(8'h00, 1'b1);
        add_word(8'hff, 1'b0);
        add_word(CH_TAB, 1'b0);
        add_word(CH_SPACE, 1'b1);
        settle();

        calm = 1'b1;
        add_strings(150);
        settle();
        calm = 1'b0;

        write_reg(CFG_DELIMITER_CHARS, random_set(0));
        write_reg(CFG_QUOTE_CHARS, random_set(0));
        add_strings(150);
        settle();

        write_reg(CFG_DELIMITER_CHARS, '0);
        write_reg(CFG_QUOTE_CHARS, '0);
        add_word(CH_SPACE, 1'b0);
        add_word(CH_DQUOTE, 1'b0);
        add_strings(100);
        settle();

        write_reg(CFG_DELIMITER_CHARS, '1);
        write_reg(CFG_QUOTE_CHARS, '1);
        add_word(8'hff, 1'b0);
        add_word(8'h61, 1'b0);
        add_word(8'hff, 1'b0);
        add_strings(100);
        settle();

        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_DELIMITER_CHARS, random_set($urandom_range(70)));
            write_reg(CFG_QUOTE_CHARS, random_set($urandom_range(70)));
            add_strings(130);
            settle();
        end

        if (fail_count == 0) begin
            $display("quoted_delimiter_tokenizer regression: pass");
        end else begin
            $display("quoted_delimiter_tokenizer regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/qdt_pkg.sv
hw/rtl/qdt_in_if.sv
hw/rtl/qdt_out_if.sv
hw/rtl/qdt_match.sv
hw/rtl/qdt_step.sv
hw/rtl/quoted_delimiter_tokenizer.sv
sim/quoted_delimiter_tokenizer_tb.sv
